// ===== rtl/udes_pkg.sv =====
// ----------------------------------------------------------------------------
// udes_pkg: shared types and codes for the USB device event sequencer
// Request and response payloads, function, event and action codes, and the
// one-hot encodings of the control-stage and sequencer state machines.
// ----------------------------------------------------------------------------
package udes_pkg;

   localparam int NUM_ENDPOINTS   = 16;
   localparam int EP0_PACKET_SIZE = 64;
   localparam int EP_W            = $clog2(NUM_ENDPOINTS);

   // request function codes
   localparam logic [2:0] FUNC_INTERRUPT = 3'd0;
   localparam logic [2:0] FUNC_SETUP_RX  = 3'd1;
   localparam logic [2:0] FUNC_OUT_READ  = 3'd2;
   localparam logic [2:0] FUNC_IN_ARMED  = 3'd3;
   localparam logic [2:0] FUNC_OUT_EN    = 3'd4;
   localparam logic [2:0] FUNC_STALL_EP0 = 3'd5;

   // notification codes
   localparam logic [3:0] EV_RESET   = 4'd0;
   localparam logic [3:0] EV_FRAME   = 4'd1;
   localparam logic [3:0] EV_RESUME  = 4'd2;
   localparam logic [3:0] EV_SUSPEND = 4'd3;
   localparam logic [3:0] EV_SETUP   = 4'd4;
   localparam logic [3:0] EV_IN      = 4'd5;
   localparam logic [3:0] EV_OUT     = 4'd6;
   localparam logic [3:0] EV_STATUS  = 4'd7;
   localparam logic [3:0] EV_NONE    = 4'd8;

   // endpoint-zero handshake actions
   localparam logic [2:0] ACT_NONE         = 3'd0;
   localparam logic [2:0] ACT_SERVICED     = 3'd1;
   localparam logic [2:0] ACT_SERVICED_END = 3'd2;
   localparam logic [2:0] ACT_TXREADY      = 3'd3;
   localparam logic [2:0] ACT_TXREADY_END  = 3'd4;
   localparam logic [2:0] ACT_STALL        = 3'd5;
   localparam logic [2:0] ACT_CLR_RXREADY  = 3'd6;

   typedef struct packed {
      logic [2:0]  func;
      logic [3:0]  bus_events;
      logic [15:0] rx_pending;
      logic [15:0] tx_pending;
      logic [3:0]  ep0_flags;
      logic [15:0] tx_busy;
      logic [3:0]  endpoint;
      logic [10:0] xfer_size;
      logic [15:0] setup_length;
   } req_type;

   typedef struct packed {
      logic [3:0] event_res;
      logic [3:0] event_endpoint;
      logic [2:0] ep_action;
      logic       last;
   } rsp_type;

   // control from the sequencer to the response holding stage
   typedef struct packed {
      logic push;
      logic flush;
   } hold_ctl_type;

   typedef enum logic [4:0] {
      STG_WAIT_SETUP = 5'b00001,
      STG_DATA_OUT   = 5'b00010,
      STG_DATA_IN    = 5'b00100,
      STG_STATUS     = 5'b01000,
      STG_IDLE       = 5'b10000
   } stage_type;

   typedef enum logic [9:0] {
      SEQ_IDLE      = 10'b0000000001,
      SEQ_CALL      = 10'b0000000010,
      SEQ_BUS       = 10'b0000000100,
      SEQ_E0_FLAGS  = 10'b0000001000,
      SEQ_E0_DUE    = 10'b0000010000,
      SEQ_E0_IN     = 10'b0000100000,
      SEQ_E0_RX     = 10'b0001000000,
      SEQ_E0_SETUP  = 10'b0010000000,
      SEQ_RX_SCAN   = 10'b0100000000,
      SEQ_TX_SCAN   = 10'b1000000000
   } seq_state_type;

endpackage

// ===== rtl/udes_alu.sv =====
// ----------------------------------------------------------------------------
// udes_alu: remaining-length unit
// Saturating subtract of a packet size from the control length and the
// last-packet compare, shared by the endpoint-zero read and arm calls.
// ----------------------------------------------------------------------------
module udes_alu
   import udes_pkg::*;
(
   input  logic [15:0] remaining,
   input  logic [10:0] size,
   output logic [15:0] diff,
   output logic        pkt_last
);

   always_comb begin
      if (16'(size) > remaining) begin
         diff = '0;
      end else begin
         diff = remaining - 16'(size);
      end
      pkt_last = (diff == '0) || (size < 11'(EP0_PACKET_SIZE));
   end

endmodule

// ===== rtl/udes_rsp_hold.sv =====
// ----------------------------------------------------------------------------
// udes_rsp_hold: one-deep response holding stage
// Delays each response by one push so the final one of a request can be
// marked as last when the sequencer flushes at the end of the request.
// ----------------------------------------------------------------------------
module udes_rsp_hold
   import udes_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  hold_ctl_type ctl,
   input  rsp_type      push_item,
   output logic         rsp_valid,
   output rsp_type      rsp_item
);

   logic    held_ff;
   logic    held_in;
   rsp_type item_ff;

   always_comb begin
      held_in   = held_ff;
      rsp_valid = 1'b0;
      rsp_item  = item_ff;
      if (ctl.push) begin
         rsp_valid     = held_ff;
         rsp_item.last = 1'b0;
         held_in       = 1'b1;
      end else if (ctl.flush) begin
         rsp_valid     = held_ff;
         rsp_item.last = 1'b1;
         held_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push) begin
         item_ff <= push_item;
      end
   end

endmodule

// ===== rtl/usb_device_event_sequencer.sv =====
// ----------------------------------------------------------------------------
// usb_device_event_sequencer: USB device control endpoint event sequencer
// Steps through interrupt snapshots and driver calls one request at a time
// and emits notifications and endpoint-zero handshake actions.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with a request on req_item while busy is low; the request is
//   taken at that clock edge and busy stays high until it is fully handled.
//   Responses appear on rsp_item for one cycle each, marked by rsp_valid;
//   rsp_item.last flags the final response of a request. There is no
//   backpressure: the receiver must take every response as it comes.
//   A driver call keeps busy high through its call step and a flush step, and
//   its response shows in the flush step; an unused function code takes only
//   the call step. An interrupt snapshot walks the four bus events, then, when
//   endpoint zero is flagged, its flags, due-status, IN and receive steps plus
//   a setup step when a setup closes an open data or status stage, then scans
//   endpoints 1 to NUM_ENDPOINTS - 1 for receive and again for IN, with one
//   more step when the last endpoint completes an IN. The shared sequencer
//   visits one bus event or one endpoint per cycle.
//   Responses come at most one per cycle, each one held in a one-deep stage
//   until the next push or the flush so the last one can be marked.
//   Reset (synchronous, active high) returns the control stage to waiting
//   for setup, marks status as reported and clears all handshake masks.
// ----------------------------------------------------------------------------
module usb_device_event_sequencer
   import udes_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   seq_state_type seq_ff, seq_in;
   stage_type     stage_ff, stage_in;
   logic [1:0]    bit_cnt_ff, bit_cnt_in;
   logic [EP_W-1:0] ep_cnt_ff, ep_cnt_in;
   logic          reported_ff, reported_in;
   logic          due_ff, due_in;
   logic          last_armed_ff, last_armed_in;
   logic          burst_ff, burst_in;
   logic [15:0]   remaining_ff, remaining_in;
   logic [NUM_ENDPOINTS-1:0] out_hs_ff, out_hs_in;
   logic [NUM_ENDPOINTS-1:0] in_wait_ff, in_wait_in;
   req_type       req_ff;

   hold_ctl_type  hold_ctl;
   rsp_type       push_item;

   // shared length unit
   logic [15:0]   alu_diff;
   logic          alu_pkt_last;

   // deferred operations, resolved after the per-state decode
   logic            tgl_en;
   logic [EP_W-1:0] tgl_ep;
   logic            rs_en;
   logic            ep_ok;
   logic [EP_W-1:0] call_ep;

   udes_alu u_alu (
      .remaining (remaining_ff),
      .size      (req_ff.xfer_size),
      .diff      (alu_diff),
      .pkt_last  (alu_pkt_last)
   );

   udes_rsp_hold u_hold (
      .clock     (clock),
      .reset     (reset),
      .ctl       (hold_ctl),
      .push_item (push_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   assign busy    = (seq_ff != SEQ_IDLE);
   assign ep_ok   = {1'b0, req_ff.endpoint} < 5'(NUM_ENDPOINTS);
   assign call_ep = req_ff.endpoint[EP_W-1:0];

   always_comb begin
      seq_in        = seq_ff;
      stage_in      = stage_ff;
      bit_cnt_in    = bit_cnt_ff;
      ep_cnt_in     = ep_cnt_ff;
      reported_in   = reported_ff;
      due_in        = due_ff;
      last_armed_in = last_armed_ff;
      burst_in      = burst_ff;
      remaining_in  = remaining_ff;
      out_hs_in     = out_hs_ff;
      in_wait_in    = in_wait_ff;
      hold_ctl      = '0;
      push_item     = '{event_res: EV_NONE, event_endpoint: 4'd0,
                        ep_action: ACT_NONE, last: 1'b0};
      tgl_en        = 1'b0;
      tgl_ep        = '0;
      rs_en         = 1'b0;

      case (seq_ff)
         SEQ_IDLE: begin
            bit_cnt_in = '0;
            if (start) begin
               seq_in = (req_item.func == FUNC_INTERRUPT) ? SEQ_BUS : SEQ_CALL;
            end
         end

         SEQ_CALL: begin
            seq_in = SEQ_IDLE;
            case (req_ff.func)
               FUNC_SETUP_RX: begin
                  remaining_in  = req_ff.setup_length;
                  last_armed_in = 1'b0;
                  hold_ctl.push = 1'b1;
                  push_item.ep_action = ACT_SERVICED;
                  seq_in = SEQ_TX_SCAN;
               end
               FUNC_OUT_READ: begin
                  if (ep_ok) begin
                     hold_ctl.push = 1'b1;
                     seq_in        = SEQ_TX_SCAN;
                     if (req_ff.endpoint == 4'd0) begin
                        remaining_in = alu_diff;
                        if (alu_pkt_last) begin
                           stage_in = STG_STATUS;
                           due_in   = 1'b1;
                           push_item.ep_action = ACT_SERVICED_END;
                        end else begin
                           push_item.ep_action = ACT_SERVICED;
                        end
                     end else begin
                        push_item.event_endpoint = req_ff.endpoint;
                        push_item.ep_action      = ACT_CLR_RXREADY;
                     end
                  end
               end
               FUNC_IN_ARMED: begin
                  if (ep_ok) begin
                     hold_ctl.push = 1'b1;
                     seq_in        = SEQ_TX_SCAN;
                     if (req_ff.endpoint == 4'd0) begin
                        remaining_in = alu_diff;
                        stage_in     = STG_DATA_IN;
                        if (alu_pkt_last) begin
                           last_armed_in = 1'b1;
                           push_item.ep_action = ACT_TXREADY_END;
                        end else begin
                           push_item.ep_action = ACT_TXREADY;
                        end
                     end else begin
                        in_wait_in[call_ep]      = 1'b1;
                        push_item.event_endpoint = req_ff.endpoint;
                        push_item.ep_action      = ACT_TXREADY;
                     end
                  end
               end
               FUNC_OUT_EN: begin
                  if (ep_ok) begin
                     tgl_en = 1'b1;
                     tgl_ep = call_ep;
                     seq_in = SEQ_TX_SCAN;
                  end
               end
               FUNC_STALL_EP0: begin
                  reported_in   = 1'b1;
                  stage_in      = STG_WAIT_SETUP;
                  hold_ctl.push = 1'b1;
                  push_item.ep_action = ACT_STALL;
                  seq_in = SEQ_TX_SCAN;
               end
               default: begin
                  seq_in = SEQ_IDLE;
               end
            endcase
            // a call finishes through the flush step: park the scan at its end
            ep_cnt_in = EP_W'(NUM_ENDPOINTS - 1);
            if (seq_in == SEQ_TX_SCAN) begin
               seq_in = SEQ_TX_SCAN;
            end
         end

         SEQ_BUS: begin
            if (bit_cnt_ff == 2'd0) begin
               if (req_ff.bus_events[0]) begin
                  if (!burst_ff) begin
                     burst_in      = 1'b1;
                     hold_ctl.push = 1'b1;
                     push_item.event_res = EV_RESET;
                  end
               end else if (req_ff.bus_events != 4'd0) begin
                  burst_in = 1'b0;
               end
            end else if (req_ff.bus_events[bit_cnt_ff]) begin
               hold_ctl.push = 1'b1;
               case (bit_cnt_ff)
                  2'd1:    push_item.event_res = EV_FRAME;
                  2'd2:    push_item.event_res = EV_RESUME;
                  default: push_item.event_res = EV_SUSPEND;
               endcase
            end
            bit_cnt_in = bit_cnt_ff + 2'd1;
            if (bit_cnt_ff == 2'd3) begin
               ep_cnt_in = EP_W'(1);
               seq_in    = req_ff.tx_pending[0] ? SEQ_E0_FLAGS : SEQ_RX_SCAN;
            end
         end

         SEQ_E0_FLAGS: begin
            // sent stall, then setup end
            if (req_ff.ep0_flags[0]) begin
               reported_in = 1'b1;
               stage_in    = STG_WAIT_SETUP;
            end
            rs_en  = req_ff.ep0_flags[1];
            seq_in = SEQ_E0_DUE;
         end

         SEQ_E0_DUE: begin
            rs_en  = due_ff;
            seq_in = SEQ_E0_IN;
         end

         SEQ_E0_IN: begin
            if (stage_ff == STG_DATA_IN && !req_ff.ep0_flags[2]) begin
               hold_ctl.push = 1'b1;
               push_item.event_res = EV_IN;
               if (last_armed_ff) begin
                  due_in = 1'b1;
               end else begin
                  stage_in = STG_IDLE;
               end
            end
            seq_in = SEQ_E0_RX;
         end

         SEQ_E0_RX: begin
            seq_in = SEQ_RX_SCAN;
            if (req_ff.ep0_flags[3]) begin
               case (stage_ff)
                  STG_WAIT_SETUP: begin
                     if (!reported_ff) begin
                        tgl_en = 1'b1;
                     end else begin
                        reported_in   = 1'b0;
                        hold_ctl.push = 1'b1;
                        push_item.event_res = EV_SETUP;
                     end
                  end
                  STG_DATA_OUT: begin
                     tgl_en = 1'b1;
                  end
                  STG_DATA_IN, STG_STATUS: begin
                     // close the status stage first, then report the setup
                     rs_en  = 1'b1;
                     seq_in = SEQ_E0_SETUP;
                  end
                  default: begin
                     // rx ready in idle stage: drop
                  end
               endcase
            end
         end

         SEQ_E0_SETUP: begin
            reported_in   = 1'b0;
            hold_ctl.push = 1'b1;
            push_item.event_res = EV_SETUP;
            seq_in = SEQ_RX_SCAN;
         end

         SEQ_RX_SCAN: begin
            if (req_ff.rx_pending[ep_cnt_ff]) begin
               tgl_en = 1'b1;
               tgl_ep = ep_cnt_ff;
            end
            if (ep_cnt_ff == EP_W'(NUM_ENDPOINTS - 1)) begin
               ep_cnt_in = EP_W'(1);
               seq_in    = SEQ_TX_SCAN;
            end else begin
               ep_cnt_in = ep_cnt_ff + EP_W'(1);
            end
         end

         SEQ_TX_SCAN: begin
            // driver calls land here with the scan parked at its end and
            // only their flush to do
            if (req_ff.func == FUNC_INTERRUPT && req_ff.tx_pending[ep_cnt_ff]
                && in_wait_ff[ep_cnt_ff] && !req_ff.tx_busy[ep_cnt_ff]) begin
               in_wait_in[ep_cnt_ff] = 1'b0;
               hold_ctl.push = 1'b1;
               push_item.event_res      = EV_IN;
               push_item.event_endpoint = 4'(ep_cnt_ff);
            end
            if (ep_cnt_ff == EP_W'(NUM_ENDPOINTS - 1)) begin
               // a push on the last endpoint repeats this step; its wait bit
               // is clear by then, so the repeat only flushes
               if (!hold_ctl.push) begin
                  seq_in = SEQ_IDLE;
               end
            end else begin
               ep_cnt_in = ep_cnt_ff + EP_W'(1);
            end
         end

         default: begin
            seq_in = SEQ_IDLE;
         end
      endcase

      // end of request: release the held response marked as last
      if (seq_ff != SEQ_IDLE && seq_in == SEQ_IDLE && !hold_ctl.push) begin
         hold_ctl.flush = 1'b1;
      end

      // OUT data toggle: report every second flag on an endpoint
      if (tgl_en) begin
         if (out_hs_ff[tgl_ep]) begin
            out_hs_in[tgl_ep] = 1'b0;
            hold_ctl.push     = 1'b1;
            push_item.event_res      = EV_OUT;
            push_item.event_endpoint = 4'(tgl_ep);
         end else begin
            out_hs_in[tgl_ep] = 1'b1;
         end
      end

      // status stage report, at most once per control transfer
      if (rs_en) begin
         due_in = 1'b0;
         if (!reported_in) begin
            reported_in   = 1'b1;
            stage_in      = STG_WAIT_SETUP;
            hold_ctl.push = 1'b1;
            push_item.event_res = EV_STATUS;
         end
      end
   end

   // Every request ends on a step without a push, so the held response is
   // always flushed as the last one before the block goes idle.
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff        <= SEQ_IDLE;
         stage_ff      <= STG_WAIT_SETUP;
         bit_cnt_ff    <= '0;
         ep_cnt_ff     <= '0;
         reported_ff   <= 1'b1;
         due_ff        <= 1'b0;
         last_armed_ff <= 1'b0;
         burst_ff      <= 1'b0;
         remaining_ff  <= '0;
         out_hs_ff     <= '0;
         in_wait_ff    <= '0;
      end else begin
         seq_ff        <= seq_in;
         stage_ff      <= stage_in;
         bit_cnt_ff    <= bit_cnt_in;
         ep_cnt_ff     <= ep_cnt_in;
         reported_ff   <= reported_in;
         due_ff        <= due_in;
         last_armed_ff <= last_armed_in;
         burst_ff      <= burst_in;
         remaining_ff  <= remaining_in;
         out_hs_ff     <= out_hs_in;
         in_wait_ff    <= in_wait_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start && !busy) begin
         req_ff <= req_item;
      end
   end

   // responses only come out while a request is in flight
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> busy)
      else $error("response outside of a request");

   // an accepted request always occupies the block for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // the last response closes the request
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last) |=> !busy)
      else $error("block still busy after last response");

   // the scan counter never leaves the endpoint range
   assert property (@(posedge clock) disable iff (reset)
      busy |-> (32'(ep_cnt_ff) < NUM_ENDPOINTS))
      else $error("endpoint scan counter out of range");

endmodule
